// ===== rtl/priority_inheritance_mutex_core_assert.svh =====
// assertion macros for the mutex core
`ifndef PRIORITY_INHERITANCE_MUTEX_CORE_ASSERT_SVH
`define PRIORITY_INHERITANCE_MUTEX_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define PIM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mutex core check failed");

// antecedent implies consequent in the next cycle
`define PIM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mutex core check failed");

`else

`define PIM_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define PIM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/pimtx_pkg.sv =====
`default_nettype none

package pimtx_pkg;

    localparam int ID_W           = 4;
    localparam int PRIO_W         = 5;
    localparam int ST_W           = 3;
    localparam int MAX_TASKS      = 16;
    localparam int PRIO_LEVELS    = 32;
    localparam int WAIT_DEPTH_DEF = 8;

    typedef logic [ST_W-1:0] t_status;

    localparam t_status ST_GRANTED = 3'd0;
    localparam t_status ST_BLOCKED = 3'd1;
    localparam t_status ST_TIMEOUT = 3'd2;
    localparam t_status ST_FREED   = 3'd3;
    localparam t_status ST_HANDED  = 3'd4;
    localparam t_status ST_FULL    = 3'd5;

    typedef logic [2:0] t_op;

    localparam t_op OP_GRANT    = 3'd0;
    localparam t_op OP_BLOCK    = 3'd1;
    localparam t_op OP_TIMEOUT  = 3'd2;
    localparam t_op OP_FULL     = 3'd3;
    localparam t_op OP_NOP_FREE = 3'd4;
    localparam t_op OP_RELEASE  = 3'd5;
    localparam t_op OP_HANDOVER = 3'd6;

    typedef struct packed {
        logic load;
        logic commit;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic unlock;
        logic no_wait;
        logic held;
        logic full;
        logic empty;
    } t_dp_stat;

    function automatic logic [PRIO_W-1:0] f_clamp_prio(input logic [PRIO_W-1:0] p);
        logic [PRIO_W-1:0] lim;
        lim = PRIO_W'(PRIO_LEVELS - 1);
        return (p > lim) ? lim : p;
    endfunction

    function automatic logic [ID_W-1:0] f_wrap_id(input logic [ID_W-1:0] id);
        return ID_W'(id % MAX_TASKS);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pimtx_ctrl.sv =====
`default_nettype none

module pimtx_ctrl
    import pimtx_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  wire t_dp_stat i_stat,
    output t_cmd          o_cmd,
    output logic          o_busy,
    output logic          o_valid
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_valid;
    t_op  w_op;

    // pick the operation from the captured request and the mutex state
    always_comb begin
        if (!i_stat.unlock) begin
            if (!i_stat.held) begin
                w_op = OP_GRANT;
            end else if (i_stat.no_wait) begin
                w_op = OP_TIMEOUT;
            end else if (i_stat.full) begin
                w_op = OP_FULL;
            end else begin
                w_op = OP_BLOCK;
            end
        end else begin
            if (!i_stat.held) begin
                w_op = OP_NOP_FREE;
            end else if (i_stat.empty) begin
                w_op = OP_RELEASE;
            end else begin
                w_op = OP_HANDOVER;
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        o_cmd.op     = w_op;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= o_cmd.commit;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

`default_nettype wire

// ===== rtl/pimtx_dp.sv =====
`default_nettype none

module pimtx_dp
    import pimtx_pkg::*;
#(
    parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire  t_cmd        i_cmd,
    input  wire               i_req_type,
    input  wire  [ID_W-1:0]   i_task_id,
    input  wire  [PRIO_W-1:0] i_task_priority,
    input  wire  [PRIO_W-1:0] i_task_base_priority,
    input  wire               i_no_wait,
    output t_dp_stat          o_stat,
    output t_status           o_status,
    output logic              o_owner_valid,
    output logic [ID_W-1:0]   o_owner_id,
    output logic [PRIO_W-1:0] o_owner_priority,
    output logic              o_reprioritize,
    output logic [ID_W-1:0]   o_adjusted_task,
    output logic [PRIO_W-1:0] o_adjusted_priority,
    output logic              o_preempt
);

    localparam int CW = $clog2(WAIT_DEPTH + 1);

    // captured request word
    logic              r_req;
    logic [ID_W-1:0]   r_tid;
    logic [PRIO_W-1:0] r_tpri;
    logic [PRIO_W-1:0] r_tbase;
    logic              r_nowait;

    // holder
    logic              r_held;
    logic [ID_W-1:0]   r_hid;
    logic [PRIO_W-1:0] r_hpri;
    logic [PRIO_W-1:0] r_hbase;
    logic              n_held;
    logic [ID_W-1:0]   n_hid;
    logic [PRIO_W-1:0] n_hpri;
    logic [PRIO_W-1:0] n_hbase;

    // sorted waiter chain, head in cell 0
    logic [ID_W-1:0]   r_wid   [WAIT_DEPTH];
    logic [PRIO_W-1:0] r_wpri  [WAIT_DEPTH];
    logic [PRIO_W-1:0] r_wbase [WAIT_DEPTH];
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     n_cnt;

    logic [WAIT_DEPTH-1:0] w_keep;
    logic [WAIT_DEPTH-1:0] w_prev_keep;
    logic [ID_W-1:0]       w_up_id   [WAIT_DEPTH];
    logic [PRIO_W-1:0]     w_up_pri  [WAIT_DEPTH];
    logic [PRIO_W-1:0]     w_up_base [WAIT_DEPTH];
    logic [ID_W-1:0]       w_dn_id   [WAIT_DEPTH];
    logic [PRIO_W-1:0]     w_dn_pri  [WAIT_DEPTH];
    logic [PRIO_W-1:0]     w_dn_base [WAIT_DEPTH];

    t_status           n_status;
    logic              n_repri;
    logic [ID_W-1:0]   n_adj_task;
    logic [PRIO_W-1:0] n_adj_pri;
    logic              n_preempt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_req_type;
            r_tid    <= f_wrap_id(i_task_id);
            r_tpri   <= f_clamp_prio(i_task_priority);
            r_tbase  <= f_clamp_prio(i_task_base_priority);
            r_nowait <= i_no_wait;
        end
    end

    assign o_stat.unlock  = r_req;
    assign o_stat.no_wait = r_nowait;
    assign o_stat.held    = r_held;
    assign o_stat.full    = (r_cnt == CW'(WAIT_DEPTH));
    assign o_stat.empty   = (r_cnt == '0);

    genvar g;
    generate
        for (g = 0; g < WAIT_DEPTH; g++) begin : g_cell
            // cells holding an equal or better priority stay where they are
            assign w_keep[g] = (CW'(g) < r_cnt) && (r_wpri[g] <= r_tpri);

            if (g == 0) begin : g_head
                assign w_prev_keep[g] = 1'b1;
                assign w_up_id[g]     = r_tid;
                assign w_up_pri[g]    = r_tpri;
                assign w_up_base[g]   = r_tbase;
            end else begin : g_body
                assign w_prev_keep[g] = w_keep[g-1];
                assign w_up_id[g]     = r_wid[g-1];
                assign w_up_pri[g]    = r_wpri[g-1];
                assign w_up_base[g]   = r_wbase[g-1];
            end

            if (g == WAIT_DEPTH - 1) begin : g_tail
                assign w_dn_id[g]   = r_wid[g];
                assign w_dn_pri[g]  = r_wpri[g];
                assign w_dn_base[g] = r_wbase[g];
            end else begin : g_mid
                assign w_dn_id[g]   = r_wid[g+1];
                assign w_dn_pri[g]  = r_wpri[g+1];
                assign w_dn_base[g] = r_wbase[g+1];
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.commit && (i_cmd.op == OP_BLOCK) && !w_keep[g]) begin
                    if (w_prev_keep[g]) begin
                        r_wid[g]   <= r_tid;
                        r_wpri[g]  <= r_tpri;
                        r_wbase[g] <= r_tbase;
                    end else begin
                        r_wid[g]   <= w_up_id[g];
                        r_wpri[g]  <= w_up_pri[g];
                        r_wbase[g] <= w_up_base[g];
                    end
                end else if (i_cmd.commit && (i_cmd.op == OP_HANDOVER)) begin
                    r_wid[g]   <= w_dn_id[g];
                    r_wpri[g]  <= w_dn_pri[g];
                    r_wbase[g] <= w_dn_base[g];
                end
            end
        end
    endgenerate

    always_comb begin
        n_held     = r_held;
        n_hid      = r_hid;
        n_hpri     = r_hpri;
        n_hbase    = r_hbase;
        n_cnt      = r_cnt;
        n_repri    = 1'b0;
        n_adj_task = '0;
        n_adj_pri  = '0;
        n_preempt  = 1'b0;
        n_status   = ST_FREED;
        case (i_cmd.op)
            OP_GRANT: begin
                n_held   = 1'b1;
                n_hid    = r_tid;
                n_hpri   = r_tpri;
                n_hbase  = r_tbase;
                n_status = ST_GRANTED;
            end
            OP_BLOCK: begin
                // inherit a better waiter priority
                if (r_tpri < r_hpri) begin
                    n_hpri     = r_tpri;
                    n_repri    = 1'b1;
                    n_adj_task = r_hid;
                    n_adj_pri  = r_tpri;
                end
                n_cnt    = r_cnt + CW'(1);
                n_status = ST_BLOCKED;
            end
            OP_TIMEOUT: begin
                n_status = ST_TIMEOUT;
            end
            OP_FULL: begin
                n_status = ST_FULL;
            end
            OP_NOP_FREE: begin
                n_status = ST_FREED;
            end
            OP_RELEASE: begin
                if (r_hpri != r_hbase) begin
                    n_repri    = 1'b1;
                    n_adj_task = r_hid;
                    n_adj_pri  = r_hbase;
                end
                n_held   = 1'b0;
                n_hid    = '0;
                n_hpri   = '0;
                n_hbase  = '0;
                n_status = ST_FREED;
            end
            OP_HANDOVER: begin
                if (r_hpri != r_hbase) begin
                    n_repri    = 1'b1;
                    n_adj_task = r_hid;
                    n_adj_pri  = r_hbase;
                end
                n_hid     = r_wid[0];
                n_hpri    = r_wpri[0];
                n_hbase   = r_wbase[0];
                n_cnt     = r_cnt - CW'(1);
                n_preempt = (r_wpri[0] < r_tpri);
                n_status  = ST_HANDED;
            end
            default: begin
                n_status = ST_FREED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 1'b0;
            r_hid   <= '0;
            r_hpri  <= '0;
            r_hbase <= '0;
            r_cnt   <= '0;
        end else if (i_cmd.commit) begin
            r_held  <= n_held;
            r_hid   <= n_hid;
            r_hpri  <= n_hpri;
            r_hbase <= n_hbase;
            r_cnt   <= n_cnt;
        end
    end

    // result word, held until the next commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_status            <= n_status;
            o_owner_valid       <= n_held;
            o_owner_id          <= n_held ? n_hid : '0;
            o_owner_priority    <= n_held ? n_hpri : '0;
            o_reprioritize      <= n_repri;
            o_adjusted_task     <= n_adj_task;
            o_adjusted_priority <= n_adj_pri;
            o_preempt           <= n_preempt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/priority_inheritance_mutex_core.sv =====
`default_nettype none
// priority inheritance mutex core
// requests come in on start/busy: a request word (lock or unlock, task id,
// effective and base priority, no-wait flag) is taken at a rising edge with
// start high and busy low. busy then stays high for one cycle.
// each request gives exactly one result word, shown on the o_ result ports
// for one cycle with o_valid high; there is no back-pressure, the receiver
// must take it in that cycle.
// o_valid is registered from the update commit and rises as busy falls.
// a new request is taken only after the update: the request is captured,
// then the sorted waiter chain inserts or pops at most one entry.
// a new request may be taken in the same cycle that o_valid is shown.
// waiters are kept in WAIT_DEPTH register cells sorted by priority, equal
// priorities in arrival order; lower number is higher priority.
// reset (synchronous, active low) frees the mutex, empties the queue and
// drops busy and o_valid; no clearing pass is needed, so start is taken as soon
// as reset is released.

`include "priority_inheritance_mutex_core_assert.svh"

module priority_inheritance_mutex_core
    import pimtx_pkg::*;
#(
    parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  wire               i_req_type,
    input  wire  [ID_W-1:0]   i_task_id,
    input  wire  [PRIO_W-1:0] i_task_priority,
    input  wire  [PRIO_W-1:0] i_task_base_priority,
    input  wire               i_no_wait,
    output logic              o_valid,
    output logic [ST_W-1:0]   o_status,
    output logic              o_owner_valid,
    output logic [ID_W-1:0]   o_owner_id,
    output logic [PRIO_W-1:0] o_owner_priority,
    output logic              o_reprioritize,
    output logic [ID_W-1:0]   o_adjusted_task,
    output logic [PRIO_W-1:0] o_adjusted_priority,
    output logic              o_preempt
);

    t_cmd     w_cmd;
    t_dp_stat w_stat;

    pimtx_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    pimtx_dp #(
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .i_req_type           (i_req_type),
        .i_task_id            (i_task_id),
        .i_task_priority      (i_task_priority),
        .i_task_base_priority (i_task_base_priority),
        .i_no_wait            (i_no_wait),
        .o_stat               (w_stat),
        .o_status             (o_status),
        .o_owner_valid        (o_owner_valid),
        .o_owner_id           (o_owner_id),
        .o_owner_priority     (o_owner_priority),
        .o_reprioritize       (o_reprioritize),
        .o_adjusted_task      (o_adjusted_task),
        .o_adjusted_priority  (o_adjusted_priority),
        .o_preempt            (o_preempt)
    );

    `PIM_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_valid)
    `PIM_ASSERT_SAME(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    `PIM_ASSERT_SAME(a_handover_held, i_clk, i_rst_n, o_valid && (o_status == ST_HANDED), o_owner_valid)
    `PIM_ASSERT_SAME(a_free_fields, i_clk, i_rst_n, o_valid && !o_owner_valid, (o_owner_id == '0) && (o_owner_priority == '0) && !o_preempt)

endmodule

`default_nettype wire

// ===== bench/priority_inheritance_mutex_core_tb.sv =====
module priority_inheritance_mutex_core_tb;
    import pimtx_pkg::*;

    localparam logic REQ_LOCK   = 1'b0;
    localparam logic REQ_UNLOCK = 1'b1;
    localparam int   RANDOM_REQS = 1880;
    localparam int   QUIET_TAIL  = 300;

    typedef struct packed {
        logic              unlock;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [PRIO_W-1:0] base;
        logic              no_wait;
    } mutex_req_t;

    typedef struct packed {
        t_status           status;
        logic              owner_valid;
        logic [ID_W-1:0]   owner_id;
        logic [PRIO_W-1:0] owner_prio;
        logic              repri;
        logic [ID_W-1:0]   adj_task;
        logic [PRIO_W-1:0] adj_prio;
        logic              preempt;
    } mutex_reply_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [PRIO_W-1:0] base;
    } waiter_t;

    class mutex_tracker;
        logic              held;
        logic [ID_W-1:0]   holder_id;
        logic [PRIO_W-1:0] holder_prio;
        logic [PRIO_W-1:0] holder_base;
        waiter_t           waiters[$];
        mutex_reply_t      pending_replies[$];
        int                errors;
        int                reply_no;

        function new();
            held        = 1'b0;
            holder_id   = '0;
            holder_prio = '0;
            holder_base = '0;
            errors      = 0;
            reply_no    = 0;
        endfunction

        function logic [PRIO_W-1:0] saturate(logic [PRIO_W-1:0] p);
            return (p > PRIO_LEVELS - 1) ? PRIO_W'(PRIO_LEVELS - 1) : p;
        endfunction

        function mutex_reply_t predict_reply(mutex_req_t r);
            mutex_reply_t      y;
            waiter_t           w;
            int                pos;
            logic [ID_W-1:0]   tid;
            logic [PRIO_W-1:0] p;
            logic [PRIO_W-1:0] b;
            y   = '0;
            tid = ID_W'(r.id % MAX_TASKS);
            p   = saturate(r.prio);
            b   = saturate(r.base);
            if (r.unlock == REQ_LOCK) begin
                if (!held) begin
                    held        = 1'b1;
                    holder_id   = tid;
                    holder_prio = p;
                    holder_base = b;
                    y.status    = ST_GRANTED;
                end else if (r.no_wait) begin
                    y.status = ST_TIMEOUT;
                end else if (waiters.size() >= WAIT_DEPTH_DEF) begin
                    y.status = ST_FULL;
                end else begin
                    // inheritance: holder takes on a better waiter priority
                    if (p < holder_prio) begin
                        holder_prio = p;
                        y.repri     = 1'b1;
                        y.adj_task  = holder_id;
                        y.adj_prio  = p;
                    end
                    pos = 0;
                    while (pos < waiters.size() && waiters[pos].prio <= p)
                        pos++;
                    w = '{id: tid, prio: p, base: b};
                    waiters.insert(pos, w);
                    y.status = ST_BLOCKED;
                end
            end else if (!held) begin
                y.status = ST_FREED;
            end else begin
                if (holder_prio != holder_base) begin
                    y.repri    = 1'b1;
                    y.adj_task = holder_id;
                    y.adj_prio = holder_base;
                end
                if (waiters.size() > 0) begin
                    w           = waiters.pop_front();
                    holder_id   = w.id;
                    holder_prio = w.prio;
                    holder_base = w.base;
                    y.preempt   = (w.prio < p);
                    y.status    = ST_HANDED;
                end else begin
                    held        = 1'b0;
                    holder_id   = '0;
                    holder_prio = '0;
                    holder_base = '0;
                    y.status    = ST_FREED;
                end
            end
            y.owner_valid = held;
            y.owner_id    = held ? holder_id : '0;
            y.owner_prio  = held ? holder_prio : '0;
            return y;
        endfunction

        function void note_request(mutex_req_t r);
            pending_replies.push_back(predict_reply(r));
        endfunction

        function void flag(string what, logic [7:0] e, logic [7:0] a);
            errors++;
            if (errors <= 10)
                $display("reply %0d %s: expected %0d, got %0d", reply_no, what, e, a);
        endfunction

        function void check_reply(mutex_reply_t got);
            mutex_reply_t e;
            reply_no++;
            if (pending_replies.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("reply %0d: result word with nothing outstanding", reply_no);
                return;
            end
            e = pending_replies.pop_front();
            if (got.status !== e.status)           flag("status", e.status, got.status);
            if (got.owner_valid !== e.owner_valid) flag("owner_valid", e.owner_valid,
                                                        got.owner_valid);
            if (got.owner_id !== e.owner_id)       flag("owner_id", e.owner_id, got.owner_id);
            if (got.owner_prio !== e.owner_prio)   flag("owner_priority", e.owner_prio,
                                                        got.owner_prio);
            if (got.repri !== e.repri)             flag("reprioritize", e.repri, got.repri);
            if (got.adj_task !== e.adj_task)       flag("adjusted_task", e.adj_task,
                                                        got.adj_task);
            if (got.adj_prio !== e.adj_prio)       flag("adjusted_priority", e.adj_prio,
                                                        got.adj_prio);
            if (got.preempt !== e.preempt)         flag("preempt", e.preempt, got.preempt);
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_req_type;
    logic [ID_W-1:0]   i_task_id;
    logic [PRIO_W-1:0] i_task_priority;
    logic [PRIO_W-1:0] i_task_base_priority;
    logic              i_no_wait;
    logic              o_valid;
    logic [ST_W-1:0]   o_status;
    logic              o_owner_valid;
    logic [ID_W-1:0]   o_owner_id;
    logic [PRIO_W-1:0] o_owner_priority;
    logic              o_reprioritize;
    logic [ID_W-1:0]   o_adjusted_task;
    logic [PRIO_W-1:0] o_adjusted_priority;
    logic              o_preempt;

    mutex_tracker sb;

    priority_inheritance_mutex_core uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_req_type          (i_req_type),
        .i_task_id           (i_task_id),
        .i_task_priority     (i_task_priority),
        .i_task_base_priority(i_task_base_priority),
        .i_no_wait           (i_no_wait),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_owner_valid       (o_owner_valid),
        .o_owner_id          (o_owner_id),
        .o_owner_priority    (o_owner_priority),
        .o_reprioritize      (o_reprioritize),
        .o_adjusted_task     (o_adjusted_task),
        .o_adjusted_priority (o_adjusted_priority),
        .o_preempt           (o_preempt)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_reply('{o_status, o_owner_valid, o_owner_id, o_owner_priority,
                             o_reprioritize, o_adjusted_task, o_adjusted_priority,
                             o_preempt});
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_request(input mutex_req_t r);
        i_req_type           = r.unlock;
        i_task_id            = r.id;
        i_task_priority      = r.prio;
        i_task_base_priority = r.base;
        i_no_wait            = r.no_wait;
        start                = 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_request(r);
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        start = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic directed(input logic unlock, input int id, input int prio,
                            input int base, input logic nw);
        send_request('{unlock, ID_W'(id), PRIO_W'(prio), PRIO_W'(base), nw});
    endtask

    function automatic logic [PRIO_W-1:0] pick_prio();
        case ($urandom_range(9))
            0:       return '0;
            1:       return PRIO_W'(PRIO_LEVELS - 1);
            default: return PRIO_W'($urandom_range(PRIO_LEVELS - 1));
        endcase
    endfunction

    function automatic mutex_req_t random_request(input int lock_pct);
        mutex_req_t r;
        int         lift;
        r.unlock  = ($urandom_range(99) >= lock_pct) ? REQ_UNLOCK : REQ_LOCK;
        r.id      = ID_W'($urandom_range(MAX_TASKS - 1));
        r.prio    = pick_prio();
        r.no_wait = ($urandom_range(99) < 12);
        // base is usually no better than the effective priority
        if ($urandom_range(3) == 0) begin
            r.base = pick_prio();
        end else begin
            lift   = r.prio + $urandom_range(8);
            r.base = (lift > PRIO_LEVELS - 1) ? PRIO_W'(PRIO_LEVELS - 1) : PRIO_W'(lift);
        end
        // most releases come from the owner at its own priority
        if (r.unlock == REQ_UNLOCK && sb.held && $urandom_range(99) < 70) begin
            r.id   = sb.holder_id;
            r.prio = sb.holder_prio;
        end
        return r;
    endfunction

    initial begin
        #2_000_000;
        $display("priority_inheritance_mutex_core_tb: done, errors");
        $finish;
    end

    initial begin
        int lock_pct;
        int wait_cnt;
        bit gaps_on;

        sb                   = new();
        i_rst_n              = 1'b0;
        start                = 1'b0;
        i_req_type           = REQ_LOCK;
        i_task_id            = '0;
        i_task_priority      = '0;
        i_task_base_priority = '0;
        i_no_wait            = 1'b0;
        lock_pct             = 55;
        gaps_on              = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // release of a free mutex, then grant with base below effective
        directed(REQ_UNLOCK, 0, 0, 0, 1'b0);
        directed(REQ_LOCK, 3, 10, 12, 1'b0);
        // owner asks again without waiting
        directed(REQ_LOCK, 3, 10, 12, 1'b1);
        directed(REQ_LOCK, 5, 20, 20, 1'b0);
        idle_cycles(3);
        // better waiter raises the owner
        directed(REQ_LOCK, 7, 2, 9, 1'b0);
        directed(REQ_LOCK, 9, 20, 25, 1'b0);
        // owner queues behind itself, waiter queues twice
        directed(REQ_LOCK, 3, 31, 31, 1'b0);
        directed(REQ_LOCK, 5, 0, 20, 1'b0);
        directed(REQ_LOCK, 15, 31, 31, 1'b0);
        idle_cycles(1);
        directed(REQ_LOCK, 0, 0, 0, 1'b0);
        directed(REQ_LOCK, 12, 15, 31, 1'b0);
        // queue is full now: no inheritance even for a top priority
        directed(REQ_LOCK, 1, 0, 0, 1'b0);
        directed(REQ_LOCK, 2, 31, 31, 1'b1);
        // drain by foreign and owner releases, then free, then free again
        for (int k = 0; k < 9; k++) begin
            if (k == 4)
                idle_cycles(7);
            directed(REQ_UNLOCK, 14 - k, (k % 2) ? 0 : 31, 31, k[0]);
        end
        directed(REQ_UNLOCK, 15, 31, 31, 1'b1);

        for (int i = 0; i < RANDOM_REQS; i++) begin
            if (i % 60 == 0) begin
                case ($urandom_range(2))
                    0:       lock_pct = 80;
                    1:       lock_pct = 30;
                    default: lock_pct = 55;
                endcase
                gaps_on = ($urandom_range(2) != 0) && (i < RANDOM_REQS - QUIET_TAIL);
            end
            if (gaps_on && $urandom_range(3) == 0)
                idle_cycles($urandom_range(1, 10));
            send_request(random_request(lock_pct));
        end
        start = 1'b0;

        wait_cnt = 0;
        while (sb.pending_replies.size() != 0 && wait_cnt < 200) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (6) @(posedge i_clk);
        if (sb.pending_replies.size() != 0) begin
            sb.errors += sb.pending_replies.size();
            $display("%0d result words never arrived", sb.pending_replies.size());
        end

        if (sb.errors == 0)
            $display("priority_inheritance_mutex_core_tb: done, clean");
        else
            $display("priority_inheritance_mutex_core_tb: done, errors");
        $finish;
    end

endmodule
